// ===== hdl/ostq_pkg.sv =====
// Shared types and constants for the one-shot timer queue.
// No dependencies; used by the controller, the datapath and the top level.
package ostq_pkg;

  localparam int SEC_W    = 31;
  localparam int USEC_W   = 20;
  localparam int HANDLE_W = 8;

  localparam logic [USEC_W-1:0] USEC_PER_SEC  = USEC_W'(1000000);
  localparam logic [USEC_W-1:0] MIN_LOAD_USEC = USEC_W'(10);

  localparam logic FUNC_REGISTER = 1'b0;
  localparam logic FUNC_EXPIRE   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // one stored timer
  typedef struct packed {
    logic [SEC_W-1:0]    sec;
    logic [USEC_W-1:0]   usec;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the input item
    logic start;    // classify the item, arm the walk
    logic walk;     // step the walk over the store
    logic load;     // write the result register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_walk;    // item changes the store
    logic walk_done;  // last entry handled this cycle
    logic out_free;   // result register can take a new item
  } dp_stat_t;

endpackage

// ===== hdl/ostq_controller.sv =====
// Sequencer for the one-shot timer queue: accept, classify, walk, head read, deliver.
// Depends on ostq_pkg.
module ostq_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ostq_pkg::dp_stat_t  stat,
  output ostq_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_HEAD,
    S_DONE
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_CHECK;
        S_CHECK: state <= stat.go_walk ? S_WALK : S_HEAD;
        S_WALK:  if (stat.walk_done) state <= S_HEAD;
        S_HEAD:  state <= S_DONE;
        S_DONE:  if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // commands
  assign in_stall    = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.start   = (state == S_CHECK);
  assign cmd.walk    = (state == S_WALK);
  assign cmd.load    = (state == S_DONE) && stat.out_free;

endmodule

// ===== hdl/ostq_datapath.sv =====
// Timer store, insertion and expiry walk, head readout and result register.
// Depends on ostq_pkg; sequenced by ostq_controller.
module ostq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ostq_pkg::ctl_cmd_t             cmd,
  output ostq_pkg::dp_stat_t             stat,
  input  logic                           func,
  input  logic [ostq_pkg::SEC_W-1:0]     duration_seconds,
  input  logic [ostq_pkg::USEC_W-1:0]    duration_micros,
  input  logic [ostq_pkg::HANDLE_W-1:0]  handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic                           fired_valid,
  output logic [ostq_pkg::HANDLE_W-1:0]  fired_handle,
  output logic                           load_valid,
  output logic [ostq_pkg::SEC_W-1:0]     load_seconds,
  output logic [ostq_pkg::USEC_W-1:0]    load_micros
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // captured item
  logic                          in_func;
  logic [ostq_pkg::SEC_W-1:0]    in_sec;
  logic [ostq_pkg::USEC_W-1:0]   in_usec;
  logic [ostq_pkg::HANDLE_W-1:0] in_handle;

  // store and walk state
  ostq_pkg::entry_t              mem [CAPACITY];
  ostq_pkg::entry_t              rd_data;
  ostq_pkg::entry_t              carry;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 ridx;
  logic [CW-1:0]                 pidx;
  logic                          pvalid;
  logic                          inserted;
  logic [ostq_pkg::SEC_W-1:0]    hs;
  logic [ostq_pkg::USEC_W-1:0]   hu;
  logic                          fired_v;
  logic [ostq_pkg::HANDLE_W-1:0] fired_h;
  ostq_pkg::status_t             op_status;

  // combinational
  ostq_pkg::status_t             op_status_next;
  ostq_pkg::entry_t              new_entry;
  ostq_pkg::entry_t              sub_entry;
  ostq_pkg::entry_t              wdata;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [CW-1:0]                 pidx_m1;
  logic                          at_end;
  logic                          ins_here;
  logic                          walk_done;
  logic                          borrow;
  logic [ostq_pkg::SEC_W:0]      need;
  logic [ostq_pkg::SEC_W:0]      sec_diff;
  logic [ostq_pkg::USEC_W:0]     usec_wrap;
  logic                          head_zero;

  // classify the captured item
  always_comb begin
    if (in_func == ostq_pkg::FUNC_REGISTER) begin
      if (in_handle == '0 || (in_sec == '0 && in_usec == '0)) begin
        op_status_next = ostq_pkg::ST_REJECT;
      end else if (count >= CW'(CAPACITY)) begin
        op_status_next = ostq_pkg::ST_FULL;
      end else begin
        op_status_next = ostq_pkg::ST_OK;
      end
    end else if (count == '0) begin
      op_status_next = ostq_pkg::ST_EMPTY;
    end else begin
      op_status_next = ostq_pkg::ST_OK;
    end
  end

  // subtract the old head from an entry, borrow into micros, clamp at zero
  always_comb begin
    borrow    = (rd_data.usec < hu);
    need      = {1'b0, hs} + {{ostq_pkg::SEC_W{1'b0}}, borrow};
    sec_diff  = {1'b0, rd_data.sec} - need;
    usec_wrap = {1'b0, rd_data.usec} + {1'b0, ostq_pkg::USEC_PER_SEC} - {1'b0, hu};
    sub_entry.handle = rd_data.handle;
    if ({1'b0, rd_data.sec} < need) begin
      sub_entry.sec  = '0;
      sub_entry.usec = '0;
    end else begin
      sub_entry.sec  = sec_diff[ostq_pkg::SEC_W-1:0];
      sub_entry.usec = borrow ? usec_wrap[ostq_pkg::USEC_W-1:0] : (rd_data.usec - hu);
    end
  end

  // walk write port
  assign new_entry = '{sec: in_sec, usec: in_usec, handle: in_handle};
  assign at_end    = (pidx == count);
  assign ins_here  = !inserted && (at_end || in_sec < rd_data.sec);
  assign pidx_m1   = pidx - CW'(1);

  always_comb begin
    we        = 1'b0;
    waddr     = pidx[AW-1:0];
    wdata     = new_entry;
    walk_done = 1'b0;
    if (cmd.walk && pvalid) begin
      if (in_func == ostq_pkg::FUNC_REGISTER) begin
        walk_done = at_end;
        if (inserted) begin
          we    = 1'b1;
          wdata = carry;
        end else if (ins_here) begin
          we = 1'b1;
        end
      end else begin
        walk_done = (pidx == count - CW'(1));
        if (pidx != '0) begin
          we    = 1'b1;
          waddr = pidx_m1[AW-1:0];
          wdata = sub_entry;
        end
      end
    end
  end

  // timer store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[ridx[AW-1:0]];
  end

  // item capture and walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ridx   <= '0;
      pvalid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        in_func   <= func;
        in_sec    <= duration_seconds;
        in_usec   <= duration_micros;
        in_handle <= handle;
      end
      if (cmd.start) begin
        op_status <= op_status_next;
        ridx      <= '0;
        pvalid    <= 1'b0;
        inserted  <= 1'b0;
        fired_v   <= 1'b0;
        fired_h   <= '0;
      end
      if (cmd.walk) begin
        if (walk_done) begin
          pvalid <= 1'b0;
          ridx   <= '0;
          count  <= (in_func == ostq_pkg::FUNC_REGISTER) ? count + CW'(1) : count - CW'(1);
        end else begin
          pvalid <= 1'b1;
          pidx   <= ridx;
          ridx   <= ridx + CW'(1);
        end
        if (pvalid) begin
          if (in_func == ostq_pkg::FUNC_REGISTER) begin
            carry <= rd_data;
            if (ins_here) inserted <= 1'b1;
          end else if (pidx == '0) begin
            hs      <= rd_data.sec;
            hu      <= rd_data.usec;
            fired_v <= 1'b1;
            fired_h <= rd_data.handle;
          end
        end
      end
    end
  end

  // result register; rd_data holds the head entry while the controller waits
  assign head_zero = (rd_data.sec == '0) && (rd_data.usec == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        out_valid    <= 1'b1;
        status       <= op_status;
        fired_valid  <= fired_v;
        fired_handle <= fired_h;
        load_valid   <= (count != '0);
        load_seconds <= (count != '0) ? rd_data.sec : '0;
        if (count == '0) begin
          load_micros <= '0;
        end else begin
          load_micros <= head_zero ? ostq_pkg::MIN_LOAD_USEC : rd_data.usec;
        end
      end
    end
  end

  assign stat.go_walk   = (op_status_next == ostq_pkg::ST_OK);
  assign stat.walk_done = walk_done;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

// ===== hdl/one_shot_timer_queue.sv =====
// One-shot timer queue, top level: controller plus datapath.
// Depends on ostq_pkg, ostq_controller and ostq_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries func, duration_seconds,
//   duration_micros and handle. func 0 registers a timer, func 1 reports that
//   the running hardware timer expired. Output channel (out_valid / out_stall)
//   returns exactly one result item per input item: status, the fired handle
//   on expiry, and the new head time to load into the hardware timer.
//   Timers are ordered by seconds only, ties in arrival order.
//   Timing: one item at a time. A rejected item, or expiry on an empty store,
//   skips the walk and goes straight to the head read. A register that is
//   taken, or an expire on a non-empty store, walks over all stored timers:
//   the walk moves one entry per cycle through the single read and write port
//   of the timer store.
//   in_stall is high from accept until the result is written to the output
//   register; the next item can then be accepted while that result waits.
//   While out_stall is high the result holds and a finished item waits.
//   Reset empties the queue; stored entries are not cleared.
module one_shot_timer_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [ostq_pkg::SEC_W-1:0]     duration_seconds,
  input  logic [ostq_pkg::USEC_W-1:0]    duration_micros,
  input  logic [ostq_pkg::HANDLE_W-1:0]  handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic                           fired_valid,
  output logic [ostq_pkg::HANDLE_W-1:0]  fired_handle,
  output logic                           load_valid,
  output logic [ostq_pkg::SEC_W-1:0]     load_seconds,
  output logic [ostq_pkg::USEC_W-1:0]    load_micros
);

  ostq_pkg::ctl_cmd_t cmd;
  ostq_pkg::dp_stat_t stat;

  ostq_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ostq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .func             (func),
    .duration_seconds (duration_seconds),
    .duration_micros  (duration_micros),
    .handle           (handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .fired_valid      (fired_valid),
    .fired_handle     (fired_handle),
    .load_valid       (load_valid),
    .load_seconds     (load_seconds),
    .load_micros      (load_micros)
  );

  // a popped timer always comes with an ok status
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired_valid |-> status == ostq_pkg::ST_OK)
    else $error("fired timer reported with a non-ok status");

  // expiry on an empty queue reports nothing else
  a_empty_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ostq_pkg::ST_EMPTY |-> !fired_valid && !load_valid)
    else $error("empty expiry reported a timer or a load value");

  // a load value is never zero
  a_load_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && load_valid && load_seconds == '0 |-> load_micros != '0)
    else $error("zero load value delivered");

  // the input side stays closed while a walk is running
  a_walk_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> in_stall)
    else $error("input open during a walk");

endmodule
